/* hw/rtl/ihb_pkg.sv */
// ----------------------------------------------------------------------------
// ihb_pkg
// Shared types and constants of the IPv4 header builder.
// ----------------------------------------------------------------------------
package ihb_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
	localparam logic [1:0] REG_SUBNET_MASK = 2'd1;
	localparam logic [1:0] REG_GATEWAY_IP  = 2'd2;

	localparam logic [15:0] VER_IHL_TOS = 16'h4500;
	localparam logic [15:0] IDENT       = 16'h0001;
	localparam logic [15:0] FLAGS_DF    = 16'h4000;
	localparam logic [7:0]  TTL         = 8'h40;
	localparam logic [15:0] HDR_BYTES   = 16'd20;
	localparam logic [18:0] FIXED_SUM   = 19'({VER_IHL_TOS} + {IDENT} + {FLAGS_DF}
		+ {TTL, 8'h00});

	localparam logic [2:0] WORD_LENGTH = 3'd0;
	localparam logic [2:0] WORD_IDENT  = 3'd1;
	localparam logic [2:0] WORD_TTL    = 3'd2;
	localparam logic [2:0] WORD_SOURCE = 3'd3;
	localparam logic [2:0] WORD_DEST   = 3'd4;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [31:0] subnet_mask;
		logic [31:0] gateway_ip;
	} ihb_cfg_t;

	typedef struct packed {
		logic [15:0] total_length;
		logic [7:0]  protocol_number;
		logic [15:0] checksum;
		logic [31:0] dest_ip;
		logic [31:0] next_hop_ip;
	} ihb_entry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} ihb_queue_status_t;

endpackage

/* hw/rtl/ihb_front.sv */
// ----------------------------------------------------------------------------
// ihb_front
// Accepts requests and computes total length, checksum and next hop in two
// pipeline stages before pushing a word into the queue.
// ----------------------------------------------------------------------------
module ihb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  ihb_pkg::ihb_cfg_t   cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         dest_ip,
	input  logic [7:0]          protocol_number,
	input  logic [15:0]         payload_length,
	input  logic                queue_full,
	output logic                push,
	output ihb_pkg::ihb_entry_t push_entry
);
	import ihb_pkg::*;

	logic        valid_s1;
	logic [31:0] dest_s1;
	logic [7:0]  proto_s1;
	logic [15:0] total_s1;
	logic [18:0] sum_s1;
	logic [31:0] hop_s1;

	logic       valid_s2;
	ihb_entry_t entry_s2;

	logic        en1;
	logic        en2;
	logic        local_dest;
	logic [19:0] acc;
	logic [16:0] fold1;
	logic [15:0] fold2;

	assign en2      = !valid_s2 || !queue_full;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;
	assign push     = valid_s2 && !queue_full;
	assign push_entry = entry_s2;

	assign local_dest = (dest_ip & cfg.subnet_mask) == (cfg.local_ip & cfg.subnet_mask);

	assign acc   = 20'(sum_s1) + 20'(total_s1) + 20'(proto_s1);
	assign fold1 = 17'(acc[15:0]) + 17'(acc[19:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			dest_s1  <= dest_ip;
			proto_s1 <= protocol_number;
			total_s1 <= payload_length + HDR_BYTES;
			sum_s1   <= FIXED_SUM + 19'(dest_ip[31:16]) + 19'(dest_ip[15:0])
				+ 19'(cfg.local_ip[31:16]) + 19'(cfg.local_ip[15:0]);
			hop_s1   <= local_dest ? dest_ip : cfg.gateway_ip;
		end
		if (en2 && valid_s1) begin
			entry_s2.total_length    <= total_s1;
			entry_s2.protocol_number <= proto_s1;
			entry_s2.checksum        <= ~fold2;
			entry_s2.dest_ip         <= dest_s1;
			entry_s2.next_hop_ip     <= hop_s1;
		end
	end

endmodule

/* hw/rtl/ihb_queue.sv */
// ----------------------------------------------------------------------------
// ihb_queue
// Small FIFO of prepared headers between front and back.
// ----------------------------------------------------------------------------
module ihb_queue #(
	parameter int DEPTH = ihb_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  ihb_pkg::ihb_entry_t        push_entry,
	input  logic                       pop,
	output ihb_pkg::ihb_entry_t        head,
	output ihb_pkg::ihb_queue_status_t status
);
	import ihb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	ihb_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign status.valid = count_q != '0;
	assign status.full  = count_q == FULL_CNT;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

/* hw/rtl/ihb_back.sv */
// ----------------------------------------------------------------------------
// ihb_back
// Walks the queued header through its five words into the output register.
// ----------------------------------------------------------------------------
module ihb_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ihb_pkg::ihb_cfg_t          cfg,
	input  ihb_pkg::ihb_entry_t        head,
	input  ihb_pkg::ihb_queue_status_t status,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [31:0]                header_word,
	output logic [2:0]                 word_number,
	output logic [31:0]                next_hop_ip,
	output logic                       last_word
);
	import ihb_pkg::*;

	logic [2:0]  idx_q;
	logic        valid_q;
	logic [31:0] word_q;
	logic [2:0]  num_q;
	logic [31:0] hop_q;
	logic        last_q;

	logic        load;
	logic [31:0] word_d;

	assign load = status.valid && (!valid_q || !out_stall);
	assign pop  = load && (idx_q == WORD_DEST);

	always_comb begin
		unique case (idx_q)
			WORD_LENGTH: word_d = {VER_IHL_TOS, head.total_length};
			WORD_IDENT:  word_d = {IDENT, FLAGS_DF};
			WORD_TTL:    word_d = {TTL, head.protocol_number, head.checksum};
			WORD_SOURCE: word_d = cfg.local_ip;
			WORD_DEST:   word_d = head.dest_ip;
			default:     word_d = head.dest_ip;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= WORD_LENGTH;
			valid_q <= 1'b0;
		end else begin
			if (load) idx_q <= (idx_q == WORD_DEST) ? WORD_LENGTH : idx_q + 1'b1;
			if (load) valid_q <= 1'b1;
			else if (!out_stall) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word_d;
			num_q  <= idx_q;
			hop_q  <= head.next_hop_ip;
			last_q <= idx_q == WORD_DEST;
		end
	end

	assign out_valid   = valid_q;
	assign header_word = word_q;
	assign word_number = num_q;
	assign next_hop_ip = hop_q;
	assign last_word   = last_q;

endmodule

/* hw/rtl/ipv4_header_builder.sv */
// ----------------------------------------------------------------------------
// ipv4_header_builder
// Builds 20-byte IPv4 headers and streams them out as five 32-bit words.
//
// Input channel: in_valid/in_stall with dest_ip, protocol_number and
// payload_length. Output channel: out_valid/out_stall with header_word,
// word_number (0..4), next_hop_ip and last_word (set on word 4).
// Registers local_ip (0x0), subnet_mask (0x4) and gateway_ip (0x8) sit on
// the APB port; write them while the block is idle.
// A taken request passes the two front stages, the queue and the output
// word register before its first word is valid; the other four follow one
// per cycle while out_stall is low. The single output word register holds
// one word at a time, so a request's words are sent before the next one's.
// A two-stage front end computes length, checksum and next hop; a two-entry
// queue lets it run ahead of the output, so in_stall rises only once both
// front stages and the queue are full.
// Reset clears the registers to zero and empties the pipeline and queue.
// A stalled output word holds; the back end waits and the front end keeps
// filling until it has no room.
// ----------------------------------------------------------------------------
module ipv4_header_builder #(
	parameter int QUEUE_DEPTH = ihb_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] dest_ip,
	input  logic [7:0]  protocol_number,
	input  logic [15:0] payload_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] header_word,
	output logic [2:0]  word_number,
	output logic [31:0] next_hop_ip,
	output logic        last_word
);
	import ihb_pkg::*;

	ihb_cfg_t          cfg_q;
	logic              push;
	logic              pop;
	ihb_entry_t        push_entry;
	ihb_entry_t        head;
	ihb_queue_status_t status;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_LOCAL_IP:    cfg_q.local_ip    <= pwdata;
				REG_SUBNET_MASK: cfg_q.subnet_mask <= pwdata;
				REG_GATEWAY_IP:  cfg_q.gateway_ip  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LOCAL_IP:    prdata = cfg_q.local_ip;
			REG_SUBNET_MASK: prdata = cfg_q.subnet_mask;
			REG_GATEWAY_IP:  prdata = cfg_q.gateway_ip;
			default:         prdata = '0;
		endcase
	end

	ihb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.dest_ip         (dest_ip),
		.protocol_number (protocol_number),
		.payload_length  (payload_length),
		.queue_full      (status.full),
		.push            (push),
		.push_entry      (push_entry)
	);

	ihb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (status)
	);

	ihb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.status      (status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.header_word (header_word),
		.word_number (word_number),
		.next_hop_ip (next_hop_ip),
		.last_word   (last_word)
	);

endmodule
